/* hw/rtl/hrpd_pkg.sv */
// Shared constants of the heart rate peak detector.
// Field widths, register indexes, reset values and sequencer state codes.
// No dependencies.
package hrpd_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned GAP_W    = 16;
  localparam int unsigned TPM_W    = 20;
  localparam int unsigned BPM_W    = 10;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned PCNT_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 20;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DROP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TPM       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_HIGH  = 3'd5;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd700;
  localparam logic [GAP_W-1:0]    MIN_GAP_RST   = 16'd10;
  localparam logic [SAMPLE_W-1:0] MAX_DROP_RST  = 12'd500;
  localparam logic [TPM_W-1:0]    TPM_RST       = 20'd60000;
  localparam logic [BPM_W-1:0]    BPM_LOW_RST   = 10'd50;
  localparam logic [BPM_W-1:0]    BPM_HIGH_RST  = 10'd250;

  localparam int unsigned ST_W = 2;
  localparam logic [ST_W-1:0] ST_IDLE = 2'd0;
  localparam logic [ST_W-1:0] ST_DIVP = 2'd1;
  localparam logic [ST_W-1:0] ST_DIVT = 2'd2;
  localparam logic [ST_W-1:0] ST_DONE = 2'd3;

  localparam int unsigned CNT_W = 5;
  localparam logic [CNT_W-1:0] DIVP_LAST = 5'd31;
  localparam logic [CNT_W-1:0] DIVT_LAST = 5'd19;

endpackage

/* hw/rtl/heart_rate_peak_detector.sv */
// Heart rate peak detector top level: slope tracking, peak qualification and
// bit-serial rate division. Depends on hrpd_pkg.
//
// One result transaction per sample transaction. A sample that does not close
// a group of PEAKS_PER_AVERAGE peaks with a rate update is evaluated, then
// handed to the output register. A sample that updates the rate is evaluated,
// then runs a one-bit-per-cycle restoring divide of the tick count by
// PEAKS_PER_AVERAGE and a one-bit-per-cycle divide of ticks_per_minute by the
// period, and is then handed to the output register.
// The output register holds a result while the sink stalls; the next sample is
// taken as soon as the current one has been handed to it. Configuration writes
// are taken in any cycle and must only be issued while the block is idle.
module heart_rate_peak_detector
  import hrpd_pkg::*;
#(
  parameter int unsigned PEAKS_PER_AVERAGE = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]   cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [11:0] sample, [15:12] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [9:0] rate_bpm, [10] peak_seen, [11] rate_updated, [12] slope_rising,
  // [15:13] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned PW = $clog2(PEAKS_PER_AVERAGE + 1);
  localparam logic [PW:0] PDIV = (PW+1)'(PEAKS_PER_AVERAGE);
  localparam logic [PCNT_W-1:0] PCMP = PCNT_W'(PEAKS_PER_AVERAGE);

  // configuration
  logic [SAMPLE_W-1:0] thr_q, drop_max_q;
  logic [GAP_W-1:0]    gap_min_q;
  logic [TPM_W-1:0]    tpm_q;
  logic [BPM_W-1:0]    bpm_low_q, bpm_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THRESHOLD_RST;
      gap_min_q  <= MIN_GAP_RST;
      drop_max_q <= MAX_DROP_RST;
      tpm_q      <= TPM_RST;
      bpm_low_q  <= BPM_LOW_RST;
      bpm_high_q <= BPM_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD: thr_q      <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_MIN_GAP:   gap_min_q  <= cfg_wdata_i[GAP_W-1:0];
        REG_MAX_DROP:  drop_max_q <= cfg_wdata_i[SAMPLE_W-1:0];
        REG_TPM:       tpm_q      <= cfg_wdata_i[TPM_W-1:0];
        REG_BPM_LOW:   bpm_low_q  <= cfg_wdata_i[BPM_W-1:0];
        REG_BPM_HIGH:  bpm_high_q <= cfg_wdata_i[BPM_W-1:0];
        default: ;
      endcase
    end
  end

  // detector state
  logic [ST_W-1:0]     state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SAMPLE_W-1:0] prev_q, prev_d;
  logic                rise_cnt_q, rise_cnt_d;
  logic                rising_q, rising_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [TICK_W-1:0]   last_pk_q, last_pk_d;
  logic [PCNT_W-1:0]   pcnt_q, pcnt_d;
  logic [BPM_W-1:0]    rate_q, rate_d;
  logic                res_pk_q, res_pk_d;
  logic                res_upd_q, res_upd_d;
  logic                out_vld_q, out_vld_d;

  // datapath registers
  logic [TICK_W-1:0]   work_q, work_d;
  logic [PW-1:0]       remp_q, remp_d;
  logic [TPM_W-1:0]    num_q, num_d;
  logic [TPM_W-1:0]    remt_q, remt_d;
  logic [OUT_TDATA_W-1:0] out_q, out_d;

  // evaluation of the incoming sample
  logic [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W-1:0] drop;
  logic [TICK_W-1:0]   since_pk;
  logic [PCNT_W-1:0]   pcnt_inc;
  logic                s_fire, is_rise, is_peak, grp_done, do_upd, out_free;

  assign smp      = s_axis_tdata[SAMPLE_W-1:0];
  assign drop     = prev_q - smp;
  assign since_pk = tick_q - last_pk_q;
  assign pcnt_inc = pcnt_q + 1'b1;
  assign is_rise  = smp > prev_q;
  assign is_peak  = !is_rise && (smp < prev_q) && (drop < drop_max_q) && rising_q &&
                    (smp > thr_q) && (since_pk > {{(TICK_W-GAP_W){1'b0}}, gap_min_q});
  assign grp_done = pcnt_inc >= PCMP;
  assign do_upd   = is_peak && grp_done &&
                    (tick_q > {{(TICK_W-GAP_W){1'b0}}, gap_min_q});

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  // divide step: tick count by the group size
  logic [PW:0] p_tmp, p_sub;
  logic        p_ge;
  assign p_tmp = {remp_q, work_q[TICK_W-1]};
  assign p_sub = p_tmp - PDIV;
  assign p_ge  = p_tmp >= PDIV;

  // divide step: ticks_per_minute by the period
  logic [TPM_W:0]    t_tmp;
  logic [TICK_W-1:0] t_ext, t_sub;
  logic              t_ge;
  logic [TPM_W-1:0]  quo;
  assign t_tmp = {remt_q, num_q[TPM_W-1]};
  assign t_ext = {{(TICK_W-TPM_W-1){1'b0}}, t_tmp};
  assign t_ge  = t_ext >= work_q;
  assign t_sub = t_ext - work_q;
  assign quo   = {num_q[TPM_W-2:0], t_ge};

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    prev_d     = prev_q;
    rise_cnt_d = rise_cnt_q;
    rising_d   = rising_q;
    tick_d     = tick_q;
    last_pk_d  = last_pk_q;
    pcnt_d     = pcnt_q;
    rate_d     = rate_q;
    res_pk_d   = res_pk_q;
    res_upd_d  = res_upd_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    work_d     = work_q;
    remp_d     = remp_q;
    num_d      = num_q;
    remt_d     = remt_q;
    out_d      = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          prev_d    = smp;
          res_pk_d  = is_peak;
          res_upd_d = do_upd;
          tick_d    = tick_q + 1'b1;
          state_d   = ST_DONE;
          if (is_rise) begin
            if (!rise_cnt_q) begin
              rise_cnt_d = 1'b1;
            end else begin
              rising_d = 1'b1;
            end
          end else if (is_peak) begin
            rising_d   = 1'b0;
            rise_cnt_d = 1'b0;
            pcnt_d     = grp_done ? '0 : pcnt_inc;
            last_pk_d  = tick_q;
            if (do_upd) begin
              last_pk_d = '0;
              tick_d    = TICK_W'(1);
              work_d    = tick_q;
              remp_d    = '0;
              cnt_d     = '0;
              state_d   = ST_DIVP;
            end
          end
        end
      end
      ST_DIVP: begin
        remp_d = p_ge ? p_sub[PW-1:0] : p_tmp[PW-1:0];
        work_d = {work_q[TICK_W-2:0], p_ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == DIVP_LAST) begin
          cnt_d   = '0;
          num_d   = tpm_q;
          remt_d  = '0;
          state_d = ST_DIVT;
        end
      end
      ST_DIVT: begin
        remt_d = t_ge ? t_sub[TPM_W-1:0] : t_tmp[TPM_W-1:0];
        num_d  = quo;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == DIVT_LAST) begin
          cnt_d = '0;
          if ((work_q == '0) || (quo < {{(TPM_W-BPM_W){1'b0}}, bpm_low_q}) ||
              (quo > {{(TPM_W-BPM_W){1'b0}}, bpm_high_q})) begin
            rate_d = '0;
          end else begin
            rate_d = quo[BPM_W-1:0];
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_d     = {3'b000, rising_q, res_upd_q, res_pk_q, rate_q};
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      prev_q     <= '0;
      rise_cnt_q <= 1'b0;
      rising_q   <= 1'b0;
      tick_q     <= '0;
      last_pk_q  <= '0;
      pcnt_q     <= '0;
      rate_q     <= '0;
      res_pk_q   <= 1'b0;
      res_upd_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      prev_q     <= prev_d;
      rise_cnt_q <= rise_cnt_d;
      rising_q   <= rising_d;
      tick_q     <= tick_d;
      last_pk_q  <= last_pk_d;
      pcnt_q     <= pcnt_d;
      rate_q     <= rate_d;
      res_pk_q   <= res_pk_d;
      res_upd_q  <= res_upd_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    remp_q <= remp_d;
    num_q  <= num_d;
    remt_q <= remt_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // checks
  a_upd_implies_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[11] || m_axis_tdata[10]))
    else $error("rate update without peak");

  a_pcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q < PCMP)
    else $error("peak count out of range");

  a_divt_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVT) |-> (cnt_q <= DIVT_LAST))
    else $error("rate divide overran");

  a_plain_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !do_upd) |=> (state_q == ST_DONE))
    else $error("plain sample did not go straight to hand-off");

  a_upd_tick_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && do_upd) |=> ((tick_q == TICK_W'(1)) && (last_pk_q == '0)))
    else $error("tick count not restarted on rate update");

endmodule
